FILE: hdl/sap_pkg.sv
// Shared types, constants and helpers of the shape area and perimeter block.
package sap_pkg;

  localparam int COORD_W             = 16;
  localparam int DIFF_W              = 16;
  localparam int SQ_W                = 33;
  localparam int SIDE_W              = 17;
  localparam int PER_W               = 19;
  localparam int AREA_W              = 25;
  localparam int TERM_W              = 19;
  localparam int PROD_W              = 38;
  localparam int HRAD_W              = 76;
  localparam int HROOT_W             = 38;
  localparam int QUEUE_DEPTH         = 4;
  localparam int COORD_FRAC_BITS_DEF = 8;

  // Pi scaled by 2^30, and twice that.
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [32:0] PI2_Q30 = 33'd6746518852;

  typedef enum logic [1:0] {
    OP_CIRCLE  = 2'd0,
    OP_RECT    = 2'd1,
    OP_TRI     = 2'd2,
    OP_UNKNOWN = 2'd3
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [DIFF_W-1:0]       rad;
    logic [2:0][DIFF_W-1:0]  dx;
    logic [2:0][DIFF_W-1:0]  dy;
  } shape_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    op_t               op;
    logic [AREA_W-1:0] area;
    logic [PER_W-1:0]  per;
  } lin_res_t;

  typedef struct packed {
    lin_res_t          lin;
    logic [PER_W-1:0]  tri_per;
  } tri_pay_t;

  // Magnitude of the difference of two signed coordinates.
  function automatic logic [DIFF_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                 logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    abs_diff = d[COORD_W] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

endpackage

FILE: hdl/sap_if.sv
// Channel interfaces for shape words and result words.
interface sap_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [15:0] coord_x1;
  logic signed [15:0] coord_y1;
  logic signed [15:0] coord_x2;
  logic signed [15:0] coord_y2;
  logic signed [15:0] coord_x3;
  logic signed [15:0] coord_y3;

  modport source(output valid, op, coord_x1, coord_y1, coord_x2, coord_y2,
                 coord_x3, coord_y3, input ready);
  modport sink(input valid, op, coord_x1, coord_y1, coord_x2, coord_y2,
               coord_x3, coord_y3, output ready);
endinterface

interface sap_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] area_out;
  logic [18:0] perimeter_out;
  logic        ok;

  modport source(output valid, area_out, perimeter_out, ok, input ready);
  modport sink(input valid, area_out, perimeter_out, ok, output ready);
endinterface

FILE: hdl/sap_isqrt.sv
// Pipelined floored square root, one root bit per stage, over several lanes.
module sap_isqrt #(
  parameter int N     = 17,
  parameter int LANES = 1,
  parameter int W     = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][2*N-1:0]     rad,
  input  logic [W-1:0]                  in_pay,
  output logic                          out_valid,
  output logic [LANES-1:0][N-1:0]       root,
  output logic [W-1:0]                  out_pay
);
  localparam int RW = N + 2;
  localparam int CW = N + 4;

  logic                          valid_r [N];
  logic [W-1:0]                  pay_r   [N];
  logic [LANES-1:0][RW-1:0]      rem_r   [N];
  logic [LANES-1:0][N-1:0]       root_r  [N];
  logic [LANES-1:0][2*N-1:0]     rad_r   [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [LANES-1:0][RW-1:0]  rem_in, rem_nxt;
    logic [LANES-1:0][N-1:0]   root_in, root_nxt;
    logic [LANES-1:0][2*N-1:0] rad_in, rad_nxt;
    logic                      valid_in;
    logic [W-1:0]              pay_in;

    if (s == 0) begin : g_first
      assign rem_in   = '0;
      assign root_in  = '0;
      assign rad_in   = rad;
      assign valid_in = in_valid;
      assign pay_in   = in_pay;
    end else begin : g_next
      assign rem_in   = rem_r[s-1];
      assign root_in  = root_r[s-1];
      assign rad_in   = rad_r[s-1];
      assign valid_in = valid_r[s-1];
      assign pay_in   = pay_r[s-1];
    end

    always_comb begin
      logic [CW-1:0] cur;
      logic [CW-1:0] trial;
      cur   = '0;
      trial = '0;
      for (int l = 0; l < LANES; l++) begin
        cur   = {rem_in[l], rad_in[l][2*N-1 -: 2]};
        trial = {2'b00, root_in[l], 2'b01};
        if (cur >= trial) begin
          rem_nxt[l]  = RW'(cur - trial);
          root_nxt[l] = {root_in[l][N-2:0], 1'b1};
        end else begin
          rem_nxt[l]  = cur[RW-1:0];
          root_nxt[l] = {root_in[l][N-2:0], 1'b0};
        end
        rad_nxt[l] = {rad_in[l][2*N-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= valid_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        root_r[s] <= root_nxt;
        rad_r[s]  <= rad_nxt;
        pay_r[s]  <= pay_in;
      end
    end
  end

  assign out_valid = valid_r[N-1];
  assign root      = root_r[N-1];
  assign out_pay   = pay_r[N-1];

endmodule

FILE: hdl/sap_front.sv
// Front end: takes shape words and turns coordinates into edge magnitudes.
module sap_front (
  input  sap_pkg::q_status_t  q_stat,
  sap_in_if.sink              in_ch,
  output logic                push,
  output sap_pkg::shape_item_t item
);
  import sap_pkg::*;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    item.op    = op_t'(in_ch.op);
    item.rad   = abs_diff(in_ch.coord_x1, '0);
    item.dx[0] = abs_diff(in_ch.coord_x2, in_ch.coord_x1);
    item.dy[0] = abs_diff(in_ch.coord_y2, in_ch.coord_y1);
    item.dx[1] = abs_diff(in_ch.coord_x3, in_ch.coord_x2);
    item.dy[1] = abs_diff(in_ch.coord_y3, in_ch.coord_y2);
    item.dx[2] = abs_diff(in_ch.coord_x1, in_ch.coord_x3);
    item.dy[2] = abs_diff(in_ch.coord_y1, in_ch.coord_y3);
  end

endmodule

FILE: hdl/sap_queue.sv
// Short queue between the front end and the arithmetic pipeline.
module sap_queue #(
  parameter int DEPTH = sap_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sap_pkg::shape_item_t  item_in,
  input  logic                  pop,
  output sap_pkg::shape_item_t  item_out,
  output sap_pkg::q_status_t    stat
);
  import sap_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  shape_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign item_out   = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

FILE: hdl/sap_back.sv
// Back end: pipelined circle, rectangle and Heron arithmetic with output register.
module sap_back #(
  parameter int COORD_FRAC_BITS = sap_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sap_pkg::q_status_t    q_stat,
  input  sap_pkg::shape_item_t  item,
  output logic                  pop,
  sap_out_if.source             out_ch
);
  import sap_pkg::*;

  logic en;

  // Stage 1: squares and simple products.
  logic                     v1_r;
  op_t                      op1_r;
  logic [2:0][SQ_W-1:0]     sq1_r;
  logic [30:0]              rr1_r;
  logic [31:0]              wh1_r;
  logic [DIFF_W:0]          rsum1_r;
  logic [PER_W-1:0]         cper1_r;
  logic [48:0]              cper_prod;

  // Stage 2: finished circle and rectangle results.
  logic                     v2_r;
  lin_res_t                 lin2_r, lin2_nxt;
  logic [2:0][SQ_W-1:0]     sq2_r;
  logic [62:0]              carea_prod;
  logic [62:0]              carea_sh;
  logic [31:0]              rarea_sh;
  logic [AREA_W-1:0]        carea, rarea;

  // Side roots.
  logic [2:0][2*SIDE_W-1:0] side_rad;
  logic [2:0][SIDE_W-1:0]   side;
  logic                     sv;
  lin_res_t                 s_lin;

  // Stages 3 to 6: Heron radicand.
  logic                     v3_r, v4_r, v5_r, v6_r;
  tri_pay_t                 pay3_r, pay4_r, pay5_r, pay6_r;
  logic [PER_W-1:0]         p_sum;
  logic signed [PER_W:0]    t0, t1, t2;
  logic                     neg;
  logic [2:0][TERM_W-1:0]   t3_r;
  logic [PROD_W-1:0]        u4_r, v4_prod_r;
  logic [56:0]              pl5_r, ph5_r;
  logic [HRAD_W-1:0]        r6_r;

  // Area root and output.
  logic [HRAD_W-1:0]        h_rad;
  logic [HROOT_W-1:0]       h_root;
  logic                     hv;
  tri_pay_t                 h_pay;
  logic [HROOT_W-1:0]       tri_sh;
  logic [AREA_W-1:0]        tri_area;

  logic                     out_valid_r;
  logic [AREA_W-1:0]        area_r;
  logic [PER_W-1:0]         per_r;
  logic                     ok_r;

  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && !q_stat.empty;

  assign cper_prod = 49'(PI2_Q30) * 49'(item.rad);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= !q_stat.empty;
      v2_r <= v1_r;
      v3_r <= sv;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= item.op;
      for (int i = 0; i < 3; i++) begin
        sq1_r[i] <= SQ_W'(32'(item.dx[i]) * 32'(item.dx[i]))
                  + SQ_W'(32'(item.dy[i]) * 32'(item.dy[i]));
      end
      rr1_r   <= 31'(32'(item.rad) * 32'(item.rad));
      wh1_r   <= 32'(item.dx[0]) * 32'(item.dy[0]);
      rsum1_r <= (DIFF_W+1)'(item.dx[0]) + (DIFF_W+1)'(item.dy[0]);
      cper1_r <= PER_W'(cper_prod >> 30);
    end
  end

  always_comb begin
    carea_prod = 63'(PI_Q30) * 63'(rr1_r);
    carea_sh   = carea_prod >> (30 + COORD_FRAC_BITS);
    rarea_sh   = wh1_r >> COORD_FRAC_BITS;
    carea      = (|carea_sh[62:AREA_W]) ? '1 : carea_sh[AREA_W-1:0];
    rarea      = (|rarea_sh[31:AREA_W]) ? '1 : rarea_sh[AREA_W-1:0];
    lin2_nxt.op   = op1_r;
    lin2_nxt.area = '0;
    lin2_nxt.per  = '0;
    case (op1_r)
      OP_CIRCLE: begin
        lin2_nxt.area = carea;
        lin2_nxt.per  = cper1_r;
      end
      OP_RECT: begin
        lin2_nxt.area = rarea;
        lin2_nxt.per  = PER_W'({rsum1_r, 1'b0});
      end
      default: begin
        lin2_nxt.area = '0;
        lin2_nxt.per  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin2_r <= lin2_nxt;
      sq2_r  <= sq1_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side_rad[i] = (2*SIDE_W)'(sq2_r[i]);
    end
  end

  sap_isqrt #(.N(SIDE_W), .LANES(3), .W($bits(lin_res_t))) u_side_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v2_r),
    .rad      (side_rad),
    .in_pay   (lin2_r),
    .out_valid(sv),
    .root     (side),
    .out_pay  (s_lin)
  );

  always_comb begin
    p_sum = PER_W'(side[0]) + PER_W'(side[1]) + PER_W'(side[2]);
    t0    = $signed({1'b0, p_sum}) - $signed({2'b00, side[0], 1'b0});
    t1    = $signed({1'b0, p_sum}) - $signed({2'b00, side[1], 1'b0});
    t2    = $signed({1'b0, p_sum}) - $signed({2'b00, side[2], 1'b0});
    neg   = t0[PER_W] || t1[PER_W] || t2[PER_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay3_r.lin     <= s_lin;
      pay3_r.tri_per <= p_sum;
      t3_r[0]        <= neg ? '0 : t0[TERM_W-1:0];
      t3_r[1]        <= neg ? '0 : t1[TERM_W-1:0];
      t3_r[2]        <= neg ? '0 : t2[TERM_W-1:0];
      pay4_r         <= pay3_r;
      u4_r           <= PROD_W'(pay3_r.tri_per) * PROD_W'(t3_r[0]);
      v4_prod_r      <= PROD_W'(t3_r[1]) * PROD_W'(t3_r[2]);
      pay5_r         <= pay4_r;
      pl5_r          <= 57'(u4_r) * 57'(v4_prod_r[18:0]);
      ph5_r          <= 57'(u4_r) * 57'(v4_prod_r[37:19]);
      pay6_r         <= pay5_r;
      r6_r           <= HRAD_W'(pl5_r) + {ph5_r, 19'b0};
    end
  end

  assign h_rad = r6_r;

  sap_isqrt #(.N(HROOT_W), .LANES(1), .W($bits(tri_pay_t))) u_area_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v6_r),
    .rad      (h_rad),
    .in_pay   (pay6_r),
    .out_valid(hv),
    .root     (h_root),
    .out_pay  (h_pay)
  );

  always_comb begin
    tri_sh   = h_root >> (COORD_FRAC_BITS + 2);
    tri_area = (|tri_sh[HROOT_W-1:AREA_W]) ? '1 : tri_sh[AREA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= hv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r <= (h_pay.lin.op != OP_UNKNOWN);
      if (h_pay.lin.op == OP_TRI) begin
        area_r <= tri_area;
        per_r  <= h_pay.tri_per;
      end else begin
        area_r <= h_pay.lin.area;
        per_r  <= h_pay.lin.per;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.area_out      = area_r;
  assign out_ch.perimeter_out = per_r;
  assign out_ch.ok            = ok_r;

endmodule

FILE: hdl/shape_area_perimeter.sv
// Top level of the shape area and perimeter block.
//
//   Channel | Role   | Word contents
//   --------+--------+------------------------------------------------------
//   in_ch   | sink   | op, coord_x1, coord_y1, coord_x2, coord_y2, coord_x3, coord_y3
//   out_ch  | source | area_out, perimeter_out, ok
//
// One word is taken per cycle while the queue is not full, and one result
// word leaves per cycle while out_ch is ready. An accepted word lands in
// the queue at the accepting edge, then passes two product stages, the 17
// stage side root, four Heron radicand stages, the 38 stage area root and
// the output register.
// Reset (rst_n low, synchronous) empties the queue and clears every valid bit.
// A stalled result holds the whole arithmetic pipeline; the four word queue
// keeps accepting words until it fills.
module shape_area_perimeter #(
  parameter int COORD_FRAC_BITS = sap_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sap_in_if.sink     in_ch,
  sap_out_if.source  out_ch
);
  import sap_pkg::*;

  q_status_t   q_stat;
  shape_item_t push_item, head_item;
  logic        push, pop;

  // The front end classifies the word and forms edge magnitudes.
  sap_front u_front (
    .q_stat(q_stat),
    .in_ch (in_ch),
    .push  (push),
    .item  (push_item)
  );

  // The queue lets the front keep taking words while the back end stalls.
  sap_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .item_in (push_item),
    .pop     (pop),
    .item_out(head_item),
    .stat    (q_stat)
  );

  // The back end runs all shape arithmetic in one lock-step pipeline.
  sap_back #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .q_stat(q_stat),
    .item  (head_item),
    .pop   (pop),
    .out_ch(out_ch)
  );

  // An unknown shape must report zero area and perimeter.
  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ok) |-> (out_ch.area_out == '0 && out_ch.perimeter_out == '0))
    else $error("unknown shape result carries nonzero fields");

  // The queue is empty right after reset, so words are taken at once.
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_ch.ready)
    else $error("input not ready after reset");

  // With the result side ready the pipeline advances and frees a queue slot.
  a_queue_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.ready && !in_ch.ready) |=> in_ch.ready)
    else $error("queue did not drain while output was ready");

endmodule
